// ----- rtl/core/fsubm_pkg.sv -----
// Package for the first-substring-match block: sizes, command and status codes.
// No dependencies; used by the channel interfaces, the top level and the bench.
package fsubm_pkg;

   localparam int PATTERN_MAX = 16;
   localparam int TEXT_MAX    = 65536;

   localparam int CMD_W    = 2;
   localparam int DATA_W   = 8;
   localparam int OFFSET_W = 16;
   localparam int STATUS_W = 2;

   // pattern length counts 0..PATTERN_MAX, text count 0..TEXT_MAX+1 (saturated)
   localparam int LEN_W = $clog2(PATTERN_MAX + 1);
   localparam int CNT_W = $clog2(TEXT_MAX + 2);

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 2'd0,
      CMD_APPEND = 2'd1,
      CMD_TEXT   = 2'd2,
      CMD_END    = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_PAT_OVF  = 2'd1,
      STATUS_TEXT_OVF = 2'd2
   } status_type;

   typedef logic [DATA_W-1:0] byte_type;

endpackage

// ----- rtl/core/fsubm_req_if.sv -----
// Request channel: valid/ready handshake carrying command and data_byte.
// Depends on fsubm_pkg for field widths.
interface fsubm_req_if;
   import fsubm_pkg::*;

   logic              valid;
   logic              ready;
   logic [CMD_W-1:0]  command;
   logic [DATA_W-1:0] data_byte;

   modport source (output valid, output command, output data_byte, input ready);
   modport sink   (input valid, input command, input data_byte, output ready);
endinterface

// ----- rtl/core/fsubm_rsp_if.sv -----
// Response channel: valid/ready handshake carrying found, match_offset and status.
// Depends on fsubm_pkg for field widths.
interface fsubm_rsp_if;
   import fsubm_pkg::*;

   logic                valid;
   logic                ready;
   logic                found;
   logic [OFFSET_W-1:0] match_offset;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output found, output match_offset, output status,
                   input ready);
   modport sink   (input valid, input found, input match_offset, input status,
                   output ready);
endinterface

// ----- rtl/core/first_substring_match_top.sv -----
// Streaming first-occurrence substring search, top level.
// An end-of-text transaction goes from the input register to the response register.
// Throughput: one request transaction per cycle; the window compare is one parallel stage,
//   and only an end-of-text waits, while the previous response is still held.
// Reset (synchronous, active high) empties the pattern and text state; no clearing pass.
// Depends on fsubm_pkg, fsubm_req_if and fsubm_rsp_if.
module first_substring_match_top (
   input  logic        clock,
   input  logic        reset,
   fsubm_req_if.sink   req_chan,
   fsubm_rsp_if.source rsp_chan
);
   import fsubm_pkg::*;

   localparam logic [CNT_W-1:0] TEXT_LIMIT = CNT_W'(TEXT_MAX);
   localparam logic [CNT_W-1:0] TEXT_SAT   = CNT_W'(TEXT_MAX + 1);

   // ---------------------------------------------------------------------------------
   // Input register: hold one accepted transaction until the search state takes it.
   // ---------------------------------------------------------------------------------
   logic     s1_valid_ff, s1_valid_in;
   cmd_type  s1_cmd_ff;
   byte_type s1_byte_ff;
   logic     s1_advance;
   logic     req_fire;

   // ---------------------------------------------------------------------------------
   // Search state.
   // pat_ff[0] is the most recently appended pattern byte, so pattern[len-1-k] sits at
   // pat_ff[k] and lines up with window_ff[k] (newest text byte) without any muxing.
   // pat_mask_ff is a thermometer code of the pattern length: bit k set when k < length.
   // ---------------------------------------------------------------------------------
   byte_type [PATTERN_MAX-1:0] pat_ff, pat_in;
   logic     [PATTERN_MAX-1:0] pat_mask_ff, pat_mask_in;
   logic     [LEN_W-1:0]       len_ff, len_in;
   logic                       overflow_ff, overflow_in;
   byte_type [PATTERN_MAX-1:0] window_ff, window_in;
   logic     [CNT_W-1:0]       count_ff, count_in;
   logic                       match_seen_ff, match_seen_in;
   logic     [OFFSET_W-1:0]    first_offset_ff, first_offset_in;

   // Response register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic                found_ff, found_in;
   logic [OFFSET_W-1:0] offset_ff, offset_in;
   status_type          status_ff, status_in;

   // Compare datapath.
   byte_type [PATTERN_MAX-1:0] win_shift;
   byte_type [PATTERN_MAX-1:0] pat_shift;
   logic     [PATTERN_MAX-1:0] lane_hit;
   logic     [CNT_W-1:0]       count_next;
   logic     [CNT_W-1:0]       match_start;
   logic                       window_full_match;
   logic                       rsp_load;

   // A pending end-of-text may only move on when the response register is free.
   assign s1_advance = s1_valid_ff &&
                       ((s1_cmd_ff != CMD_END) || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign s1_valid_in    = req_fire || (s1_valid_ff && !s1_advance);
   assign rsp_load       = s1_advance && (s1_cmd_ff == CMD_END);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      // payload only loads with a new transaction
      if (req_fire) begin
         s1_cmd_ff  <= cmd_type'(req_chan.command);
         s1_byte_ff <= req_chan.data_byte;
      end
   end

   // Shift the new byte in at lane 0 for both the text window and the pattern.
   always_comb begin
      win_shift[0] = s1_byte_ff;
      pat_shift[0] = s1_byte_ff;
      for (int k = 1; k < PATTERN_MAX; k++) begin
         win_shift[k] = window_ff[k-1];
         pat_shift[k] = pat_ff[k-1];
      end
   end

   // Parallel compare: every lane inside the pattern must agree.
   always_comb begin
      for (int k = 0; k < PATTERN_MAX; k++) begin
         lane_hit[k] = !pat_mask_ff[k] || (win_shift[k] == pat_ff[k]);
      end
   end

   assign count_next        = count_ff + CNT_W'(1);
   assign window_full_match = (&lane_hit) && (len_ff != '0) &&
                              (32'(count_next) >= 32'(len_ff));
   // only used when count_next >= length, so the length fits the count width
   assign match_start       = count_next - CNT_W'(len_ff);

   // Next search state.
   always_comb begin
      pat_in          = pat_ff;
      pat_mask_in     = pat_mask_ff;
      len_in          = len_ff;
      overflow_in     = overflow_ff;
      window_in       = window_ff;
      count_in        = count_ff;
      match_seen_in   = match_seen_ff;
      first_offset_in = first_offset_ff;
      if (s1_advance) begin
         case (s1_cmd_ff)
            CMD_CLEAR: begin
               // drop pattern and text; stale pattern bytes are masked off
               pat_mask_in     = '0;
               len_in          = '0;
               overflow_in     = 1'b0;
               count_in        = '0;
               match_seen_in   = 1'b0;
               first_offset_in = '0;
            end
            CMD_APPEND: begin
               if (32'(len_ff) < 32'(PATTERN_MAX)) begin
                  pat_in      = pat_shift;
                  pat_mask_in = {pat_mask_ff[PATTERN_MAX-2:0], 1'b1};
                  len_in      = len_ff + LEN_W'(1);
               end else begin
                  overflow_in = 1'b1;
               end
            end
            CMD_TEXT: begin
               if (count_ff >= TEXT_LIMIT) begin
                  // saturate: the extra value marks an over-long text
                  count_in = TEXT_SAT;
               end else begin
                  window_in = win_shift;
                  count_in  = count_next;
                  if (!match_seen_ff && window_full_match) begin
                     match_seen_in   = 1'b1;
                     first_offset_in = (32'(match_start) > 32'(16'hFFFF)) ?
                                       16'hFFFF : OFFSET_W'(match_start);
                  end
               end
            end
            CMD_END: begin
               // keep the pattern, restart the text
               count_in        = '0;
               match_seen_in   = 1'b0;
               first_offset_in = '0;
            end
            default: begin
               pat_in = pat_ff;
            end
         endcase
      end
   end

   // Response fields for an end-of-text transaction.
   always_comb begin
      found_in  = 1'b0;
      offset_in = '0;
      status_in = STATUS_OK;
      if (overflow_ff) begin
         status_in = STATUS_PAT_OVF;
      end else begin
         if (len_ff == '0) begin
            found_in = 1'b1;
         end else if (match_seen_ff) begin
            found_in  = 1'b1;
            offset_in = first_offset_ff;
         end
         if (count_ff == TEXT_SAT) begin
            status_in = STATUS_TEXT_OVF;
         end
      end
   end

   // Hold the response until taken; load a new one as the old one leaves.
   assign rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_mask_ff     <= '0;
         len_ff          <= '0;
         overflow_ff     <= 1'b0;
         count_ff        <= '0;
         match_seen_ff   <= 1'b0;
         first_offset_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         pat_mask_ff     <= pat_mask_in;
         len_ff          <= len_in;
         overflow_ff     <= overflow_in;
         count_ff        <= count_in;
         match_seen_ff   <= match_seen_in;
         first_offset_ff <= first_offset_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
      // window and pattern bytes are only read inside the valid length and count
      pat_ff    <= pat_in;
      window_ff <= window_in;
      if (rsp_load) begin
         found_ff  <= found_in;
         offset_ff <= offset_in;
         status_ff <= status_in;
      end
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.found        = found_ff;
   assign rsp_chan.match_offset = offset_ff;
   assign rsp_chan.status       = status_ff;

   // ---------------------------------------------------------------------------------
   // Checks.
   // ---------------------------------------------------------------------------------
   // A response only appears right after an end-of-text left the input register.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(s1_valid_ff && (s1_cmd_ff == CMD_END)))
      else $error("response raised without an end-of-text transaction");

   // The length thermometer and the length counter agree.
   assert property (@(posedge clock) disable iff (reset)
      $countones(pat_mask_ff) == 32'(len_ff))
      else $error("pattern mask and length disagree");

   // A recorded match needs a non-empty pattern.
   assert property (@(posedge clock) disable iff (reset)
      match_seen_ff |-> (len_ff != '0))
      else $error("match recorded with empty pattern");

   // Pattern overflow reports nothing found at offset zero.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (status_ff == STATUS_PAT_OVF)) |-> (!found_ff && (offset_ff == '0)))
      else $error("pattern overflow response carries a match");

endmodule

// ----- bench/first_substring_match_checker.sv -----
`timescale 1ns / 100ps
// Search checker: watches the request and response channels of the substring matcher,
// predicts each end-of-text report and compares it field by field.
// Depends on fsubm_pkg, fsubm_req_if and fsubm_rsp_if.
module first_substring_match_checker (
   input  logic  clock,
   input  logic  reset,
   fsubm_req_if  req_mon,
   fsubm_rsp_if  rsp_mon,
   output int    mismatches,
   output int    outstanding
);
   import fsubm_pkg::*;

   typedef struct packed {
      logic                found;
      logic [OFFSET_W-1:0] match_offset;
      status_type          status;
   } search_report_type;

   search_report_type   expected_reports[$];

   byte_type            pat_store [PATTERN_MAX];
   logic [LEN_W-1:0]    pat_len;
   logic                pat_ovf;
   byte_type            window [PATTERN_MAX];   // entry 0 holds the newest text byte
   logic [CNT_W-1:0]    text_count;
   logic                seen;
   logic [OFFSET_W-1:0] first_off;

   initial begin
      mismatches  = 0;
      outstanding = 0;
   end

   // Newest pat_len window bytes against the pattern, last pattern byte first.
   function automatic bit window_hits();
      for (int k = 0; k < PATTERN_MAX; k++) begin
         if (k < pat_len && window[k] != pat_store[pat_len - 1 - k]) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic drop_text();
      foreach (window[i]) window[i] = '0;
      text_count = '0;
      seen       = 1'b0;
      first_off  = '0;
   endtask

   task automatic advance_search(input cmd_type cmd, input byte_type data);
      search_report_type rep;
      int unsigned       start;
      case (cmd)
         CMD_CLEAR: begin
            pat_len = '0;
            pat_ovf = 1'b0;
            drop_text();
         end
         CMD_APPEND: begin
            if (pat_len < PATTERN_MAX) begin
               pat_store[pat_len] = data;
               pat_len++;
            end else begin
               pat_ovf = 1'b1;
            end
         end
         CMD_TEXT: begin
            if (text_count >= TEXT_MAX) begin
               // saturate one past the limit to mark an over-long text
               text_count = CNT_W'(TEXT_MAX + 1);
            end else begin
               for (int i = PATTERN_MAX - 1; i > 0; i--) window[i] = window[i-1];
               window[0] = data;
               text_count++;
               if (!seen && pat_len != 0 && text_count >= pat_len && window_hits()) begin
                  start     = text_count - pat_len;
                  seen      = 1'b1;
                  first_off = (start > 32'hFFFF) ? 16'hFFFF : OFFSET_W'(start);
               end
            end
         end
         CMD_END: begin
            rep        = '0;
            rep.status = STATUS_OK;
            if (pat_ovf) begin
               rep.status = STATUS_PAT_OVF;
            end else begin
               if (pat_len == 0) begin
                  rep.found = 1'b1;
               end else if (seen) begin
                  rep.found        = 1'b1;
                  rep.match_offset = first_off;
               end
               if (text_count > TEXT_MAX) rep.status = STATUS_TEXT_OVF;
            end
            expected_reports = {expected_reports, rep};
            drop_text();
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      search_report_type want;
      if (reset) begin
         foreach (pat_store[i]) pat_store[i] = '0;
         pat_len = '0;
         pat_ovf = 1'b0;
         drop_text();
         expected_reports.delete();
      end else begin
         // A report never leaves in the cycle its request is taken, so check first.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_reports.size() == 0) begin
               $error("unexpected response transaction: found %0d offset %0d status %0d",
                      rsp_mon.found, rsp_mon.match_offset, rsp_mon.status);
               mismatches++;
            end else begin
               want = expected_reports.pop_front();
               if (rsp_mon.found !== want.found) begin
                  $error("found: expected %0d, actual %0d", want.found, rsp_mon.found);
                  mismatches++;
               end
               if (rsp_mon.match_offset !== want.match_offset) begin
                  $error("match_offset: expected %0d, actual %0d",
                         want.match_offset, rsp_mon.match_offset);
                  mismatches++;
               end
               if (rsp_mon.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_mon.status);
                  mismatches++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready)
            advance_search(cmd_type'(req_mon.command), req_mon.data_byte);
      end
      outstanding = expected_reports.size();
   end

endmodule

// ----- bench/first_substring_match_top_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for the first-substring-match block: clock, reset, request stimulus,
// response back-pressure and the final verdict. Depends on fsubm_pkg, both channel
// interfaces, first_substring_match_top and first_substring_match_checker.
module first_substring_match_top_tb;
   import fsubm_pkg::*;

   localparam int CYCLE_LIMIT     = 600000;
   localparam int RANDOM_ITEMS    = 950;
   localparam int HOLD_OFF_CYCLES = 300;

   logic     clock;
   logic     reset;
   int       mismatch_count;
   int       outstanding_count;
   int       cycle_count = 0;
   int       hold_cycles = 0;    // receiver hold-off still to run, in cycles
   int       items_sent  = 0;
   bit       gaps_on     = 1'b1; // random idling on both channels
   bit       pressure_done;
   byte_type loaded_pat[$];      // pattern as the stimulus believes it is loaded
   byte_type sym_a = 8'h5A;      // two-symbol alphabet so that matches come often
   byte_type sym_b = 8'hA5;

   fsubm_req_if req_chan();
   fsubm_rsp_if rsp_chan();

   first_substring_match_top dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   first_substring_match_checker match_check (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_chan),
      .rsp_mon     (rsp_chan),
      .mismatches  (mismatch_count),
      .outstanding (outstanding_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog: end the run if the block hangs.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("first_substring_match_top_tb failed");
         $finish;
      end
   end

   // Response side: drop ready at random, or hold it low for a counted stretch
   // when the stimulus asks for back-pressure.
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_cycles--;
         end else if (gaps_on) begin
            rsp_chan.ready <= ($urandom_range(99) >= 34);
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   function automatic byte_type pick_sym();
      if ($urandom_range(15) == 0) return byte_type'($urandom);
      return $urandom_range(1) ? sym_a : sym_b;
   endfunction

   // Offer one request transaction at the falling edge and hold it until taken.
   // Valid stays high into the next transaction unless an idle cycle is drawn.
   task automatic send_item(input cmd_type cmd, input byte_type data);
      if (gaps_on) begin
         while ($urandom_range(99) < 34) begin
            req_chan.valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_chan.valid     <= 1'b1;
      req_chan.command   <= cmd;
      req_chan.data_byte <= data;
      do @(posedge clock); while (req_chan.ready !== 1'b1);
      @(negedge clock);
      items_sent++;
      // track the pattern so that random texts can carry it
      case (cmd)
         CMD_CLEAR:  loaded_pat.delete();
         CMD_APPEND: if (loaded_pat.size() < PATTERN_MAX) loaded_pat = {loaded_pat, data};
         default: ;
      endcase
   endtask

   // One random search: mostly a well-formed clear / pattern / text / end sequence,
   // sometimes a burst of arbitrary transactions.
   task automatic random_search();
      byte_type text_buf[$];
      int       pat_n;
      int       text_n;
      int       pos;
      int       mid;
      if ($urandom_range(99) < 8) begin
         repeat ($urandom_range(1, 6))
            send_item(cmd_type'($urandom_range(3)), byte_type'($urandom));
         return;
      end
      // New pattern: mostly short, sometimes longer up to full length, now and then overflowing
      // or left empty.
      if (loaded_pat.size() == 0 || $urandom_range(2) == 0) begin
         send_item(CMD_CLEAR, byte_type'($urandom));
         sym_a = byte_type'($urandom);
         sym_b = $urandom_range(1) ? ~sym_a : sym_a ^ (8'h01 << $urandom_range(7));
         pat_n = $urandom_range(99);
         pat_n = (pat_n < 5)  ? 0 :
                 (pat_n < 75) ? $urandom_range(1, 4) :
                 (pat_n < 94) ? $urandom_range(5, PATTERN_MAX) :
                                $urandom_range(PATTERN_MAX + 1, PATTERN_MAX + 2);
         repeat (pat_n) send_item(CMD_APPEND, pick_sym());
      end
      text_n = ($urandom_range(9) == 0) ? $urandom_range(25, 60) : $urandom_range(0, 24);
      for (int i = 0; i < text_n; i++) text_buf = {text_buf, pick_sym()};
      // plant the pattern at a random place in about half of the texts
      if (loaded_pat.size() > 0 && loaded_pat.size() <= text_n && $urandom_range(1)) begin
         pos = $urandom_range(text_n - loaded_pat.size());
         foreach (loaded_pat[k]) text_buf[pos + k] = loaded_pat[k];
      end
      // occasionally grow the pattern in the middle of the text
      mid = ($urandom_range(9) == 0) ? $urandom_range(text_n) : -1;
      foreach (text_buf[i]) begin
         if (i == mid) send_item(CMD_APPEND, pick_sym());
         send_item(CMD_TEXT, text_buf[i]);
      end
      send_item(CMD_END, byte_type'($urandom));
   endtask

   initial begin
      req_chan.valid     = 1'b0;
      req_chan.command   = CMD_CLEAR;
      req_chan.data_byte = '0;
      reset              = 1'b1;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Empty pattern after an empty text still reports a match at offset 0.
      send_item(CMD_END, 8'h00);

      // Extreme byte values as a two-byte pattern; first match starts at offset 1.
      send_item(CMD_APPEND, 8'h00);
      send_item(CMD_APPEND, 8'hFF);
      send_item(CMD_TEXT, 8'hFF);
      send_item(CMD_TEXT, 8'h00);
      send_item(CMD_TEXT, 8'hFF);
      send_item(CMD_END, 8'hFF);

      // Pattern longer than the text: no match.
      send_item(CMD_TEXT, 8'h00);
      send_item(CMD_END, 8'h5A);

      // Grow the pattern mid-text; the match uses a byte taken before the append.
      send_item(CMD_TEXT, 8'h00);
      send_item(CMD_APPEND, 8'h3C);
      send_item(CMD_TEXT, 8'hFF);
      send_item(CMD_TEXT, 8'h3C);
      send_item(CMD_END, 8'h00);

      // Overflow the pattern store; the flag masks the search until a clear.
      repeat (PATTERN_MAX - 1) send_item(CMD_APPEND, 8'hC3);
      send_item(CMD_TEXT, 8'hC3);
      send_item(CMD_END, 8'h00);

      // Clear empties pattern and overflow flag.
      send_item(CMD_CLEAR, 8'hFF);
      send_item(CMD_END, 8'h00);

      // Random part. Partway in, hold off the receiver while end-of-text
      // transactions keep coming so the block backs up; later, run a stretch
      // with no idling on either side.
      items_sent    = 0;
      pressure_done = 1'b0;
      while (items_sent < RANDOM_ITEMS) begin
         gaps_on = !(items_sent >= 600 && items_sent < 800);
         if (!pressure_done && items_sent >= 350) begin
            pressure_done = 1'b1;
            hold_cycles   = HOLD_OFF_CYCLES;
            repeat (40) begin
               send_item(CMD_TEXT, pick_sym());
               send_item(CMD_END, byte_type'($urandom));
            end
         end else begin
            random_search();
         end
      end
      gaps_on = 1'b1;
      req_chan.valid <= 1'b0;

      // Drain outstanding reports, then allow for the pipeline latency.
      wait (outstanding_count == 0);
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("first_substring_match_top_tb passed");
      else
         $display("first_substring_match_top_tb failed");
      $finish;
   end

endmodule
